### src/assert_macros.svh
// Concurrent assertion helpers; every user has clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset.
`define NIRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expr must never be true outside reset.
`define NIRT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### src/nirt_pkg.sv
`timescale 1ns / 1ps

package nirt_pkg;

	localparam int UID_W     = 64;
	localparam int ADDR_W    = 8;
	localparam int OUT_CNT_W = 5;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// control part of the item travelling along the cell row
	typedef struct packed {
		logic valid;
		logic mode;   // 0 lookup, 1 add
		logic done;   // lookup hit or add placed
	} tok_ctl_t;

endpackage

### src/nirt_cell.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module nirt_cell #(
	parameter int TABLE_DEPTH = 16,
	parameter int ID_W        = 64,
	parameter int CNT_W       = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  nirt_pkg::tok_ctl_t       ctl_i,
	input  logic [ID_W-1:0]          id_i,
	input  logic [nirt_pkg::ADDR_W-1:0] addr_i,
	input  logic [nirt_pkg::ADDR_W-1:0] found_i,
	input  logic [TABLE_DEPTH-1:0]   used_i,
	input  logic [CNT_W-1:0]         cnt_i,
	output nirt_pkg::tok_ctl_t       ctl_o,
	output logic [ID_W-1:0]          id_o,
	output logic [nirt_pkg::ADDR_W-1:0] addr_o,
	output logic [nirt_pkg::ADDR_W-1:0] found_o,
	output logic [TABLE_DEPTH-1:0]   used_o,
	output logic [CNT_W-1:0]         cnt_o
);
	import nirt_pkg::*;

	// entry held by this cell
	logic              valid_q;
	logic [ID_W-1:0]   id_q;
	logic [ADDR_W-1:0] addr_q;

	// item stage register
	tok_ctl_t          ctl_s1;
	logic [ID_W-1:0]   id_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [ADDR_W-1:0] found_s1;
	logic [TABLE_DEPTH-1:0] used_s1;
	logic [CNT_W-1:0]  cnt_s1;

	logic              hit;
	logic              place;
	logic              eff_v;
	logic [ADDR_W-1:0] eff_addr;
	tok_ctl_t          ctl_nx;
	logic [ADDR_W-1:0] found_nx;
	logic [TABLE_DEPTH-1:0] used_nx;
	logic [CNT_W-1:0]  cnt_nx;

	always_comb begin
		hit      = valid_q && (id_q == id_i);
		place    = ctl_i.mode && !ctl_i.done && !valid_q;
		eff_v    = valid_q || place;
		eff_addr = place ? addr_i : addr_q;
		ctl_nx       = ctl_i;
		ctl_nx.done  = ctl_i.done || (ctl_i.mode ? place : hit);
		found_nx = (!ctl_i.mode && !ctl_i.done && hit) ? addr_q : found_i;
		for (int j = 0; j < TABLE_DEPTH; j++) begin
			used_nx[j] = used_i[j] || (eff_v && (eff_addr == ADDR_W'(j + 1)));
		end
		cnt_nx = cnt_i + CNT_W'(eff_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ctl_s1  <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_nx;
			if (ctl_i.valid && place) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			id_s1       <= id_i;
			addr_s1     <= addr_i;
			found_s1    <= found_nx;
			used_s1     <= used_nx;
			cnt_s1      <= cnt_nx;
			if (ctl_i.valid && place) begin
				id_q   <= id_i;
				addr_q <= addr_i;
			end
		end
	end

	assign ctl_o   = ctl_s1;
	assign id_o    = id_s1;
	assign addr_o  = addr_s1;
	assign found_o = found_s1;
	assign used_o  = used_s1;
	assign cnt_o   = cnt_s1;

	`NIRT_NEVER(a_valid_sticky, $fell(valid_q), "entry valid mark cleared")
	`NIRT_ASSERT(a_write_only_free, (adv && ctl_i.valid && place) |-> !valid_q, "overwrote entry")
	`NIRT_ASSERT(a_hold_on_stall, !adv |=> $stable(ctl_s1), "row moved while stalled")

endmodule

### src/node_id_registry_table.sv
`timescale 1ns / 1ps

// channel | valid     | stall     | fields
// --------+-----------+-----------+------------------------------------------------
// request | req_valid | req_stall | mode, unique_id, node_address
// result  | rsp_valid | rsp_stall | status, found_address, next_free_address,
//         |           |           | entry_count
//
// The result is registered: the item walks the row of cells, one cell per cycle unless
// the row is frozen, then lands in the result register. A new item can enter every
// cycle while req_stall is low.
// Reset clears every entry valid mark and empties the row.
// A stalled result freezes the whole row; req_stall is high while it waits.

`include "assert_macros.svh"

module node_id_registry_table #(
	parameter int TABLE_DEPTH = 16,
	parameter int ID_BYTES    = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic                            mode,
	input  logic [nirt_pkg::UID_W-1:0]      unique_id,
	input  logic [nirt_pkg::ADDR_W-1:0]     node_address,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [1:0]                      status,
	output logic [nirt_pkg::ADDR_W-1:0]     found_address,
	output logic [nirt_pkg::OUT_CNT_W-1:0]  next_free_address,
	output logic [nirt_pkg::OUT_CNT_W-1:0]  entry_count
);
	import nirt_pkg::*;

	localparam int ID_W  = 8 * ID_BYTES;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

	tok_ctl_t               ctl_c   [0:TABLE_DEPTH];
	logic [ID_W-1:0]        id_c    [0:TABLE_DEPTH];
	logic [ADDR_W-1:0]      addr_c  [0:TABLE_DEPTH];
	logic [ADDR_W-1:0]      found_c [0:TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] used_c  [0:TABLE_DEPTH];
	logic [CNT_W-1:0]       cnt_c   [0:TABLE_DEPTH];

	logic                   adv;
	logic                   rsp_valid_q;
	status_t                status_q;
	logic [ADDR_W-1:0]      found_q;
	logic [CNT_W-1:0]       free_q;
	logic [CNT_W-1:0]       cnt_q;
	status_t                status_nx;
	logic [CNT_W-1:0]       free_nx;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign req_stall = !adv;

	always_comb begin
		ctl_c[0].valid = req_valid;
		ctl_c[0].mode  = mode;
		ctl_c[0].done  = 1'b0;
		id_c[0]        = unique_id[ID_W-1:0];
		addr_c[0]      = node_address;
		found_c[0]     = '0;
		used_c[0]      = '0;
		cnt_c[0]       = '0;
	end

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		nirt_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.ID_W       (ID_W),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.ctl_i  (ctl_c[i]),
			.id_i   (id_c[i]),
			.addr_i (addr_c[i]),
			.found_i(found_c[i]),
			.used_i (used_c[i]),
			.cnt_i  (cnt_c[i]),
			.ctl_o  (ctl_c[i+1]),
			.id_o   (id_c[i+1]),
			.addr_o (addr_c[i+1]),
			.found_o(found_c[i+1]),
			.used_o (used_c[i+1]),
			.cnt_o  (cnt_c[i+1])
		);
	end

	always_comb begin
		if (ctl_c[TABLE_DEPTH].done) begin
			status_nx = ST_OK;
		end else if (ctl_c[TABLE_DEPTH].mode) begin
			status_nx = ST_FULL;
		end else begin
			status_nx = ST_NOT_FOUND;
		end
		free_nx = '0;
		for (int j = TABLE_DEPTH - 1; j >= 0; j--) begin
			if (!used_c[TABLE_DEPTH][j]) begin
				free_nx = CNT_W'(j + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= ctl_c[TABLE_DEPTH].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= status_nx;
			found_q  <= found_c[TABLE_DEPTH];
			free_q   <= free_nx;
			cnt_q    <= cnt_c[TABLE_DEPTH];
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign status            = status_q;
	assign found_address     = found_q;
	assign next_free_address = OUT_CNT_W'(free_q);
	assign entry_count       = OUT_CNT_W'(cnt_q);

	`NIRT_ASSERT(a_cnt_bound, rsp_valid_q |-> (cnt_q <= DEPTH_CNT), "count over depth")
	`NIRT_ASSERT(a_full_cnt, (rsp_valid_q && status_q == ST_FULL) |-> (cnt_q == DEPTH_CNT), "full")
	`NIRT_ASSERT(a_nofree_cnt, (rsp_valid_q && free_q == '0) |-> (cnt_q == DEPTH_CNT), "no free")

endmodule

### tb/sv/node_id_registry_table_tb.sv
`timescale 1ns / 1ps

module node_id_registry_table_tb;
	import nirt_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int ID_BYTES    = 8;
	localparam int RAND_ITEMS  = 2000;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_ADD    = 1'b1;

	localparam logic [UID_W-1:0] ID_MASK =
		(ID_BYTES >= 8) ? '1 : ((64'd1 << (8 * ID_BYTES)) - 64'd1);

	typedef struct {
		logic               mode;
		logic [UID_W-1:0]   uid;
		logic [ADDR_W-1:0]  addr;
	} node_req_t;

	typedef struct {
		status_t               st;
		logic [ADDR_W-1:0]     found;
		logic [OUT_CNT_W-1:0]  next_free;
		logic [OUT_CNT_W-1:0]  count;
	} node_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic mode = MODE_LOOKUP;
	logic [UID_W-1:0] unique_id = '0;
	logic [ADDR_W-1:0] node_address = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [1:0] status;
	logic [ADDR_W-1:0] found_address;
	logic [OUT_CNT_W-1:0] next_free_address;
	logic [OUT_CNT_W-1:0] entry_count;

	node_id_registry_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.ID_BYTES   (ID_BYTES)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.mode             (mode),
		.unique_id        (unique_id),
		.node_address     (node_address),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.status           (status),
		.found_address    (found_address),
		.next_free_address(next_free_address),
		.entry_count      (entry_count)
	);

	always #5 clk = ~clk;

	// registry shadow
	logic [UID_W-1:0]  reg_id   [TABLE_DEPTH];
	logic [ADDR_W-1:0] reg_addr [TABLE_DEPTH];
	bit                reg_used [TABLE_DEPTH];
	int unsigned       reg_count = 0;

	node_req_t pending_reqs[$];
	node_rsp_t expected_rsps[$];

	// stimulus-side view of what has been enrolled
	logic [UID_W-1:0] gen_ids[$];
	int gen_adds = 0;
	int seq_addr = 3;

	int err_cnt = 0;
	int cyc = 0;
	int n_hit = 0, n_miss = 0, n_placed = 0, n_refused = 0;

	wire quiet = (cyc >= 1000 && cyc < 1800);

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			reg_id[i] = '0;
			reg_addr[i] = '0;
			reg_used[i] = 1'b0;
		end
	end

	function automatic logic [OUT_CNT_W-1:0] lowest_free_address();
		bit taken;
		for (int a = 1; a <= TABLE_DEPTH; a++) begin
			taken = 1'b0;
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (reg_used[i] && reg_addr[i] == a)
					taken = 1'b1;
			if (!taken)
				return OUT_CNT_W'(a);
		end
		return '0;
	endfunction

	function automatic node_rsp_t apply_registry(node_req_t it);
		node_rsp_t r;
		logic [UID_W-1:0] key;
		key = it.uid & ID_MASK;
		r.found = '0;
		if (it.mode == MODE_LOOKUP) begin
			r.st = ST_NOT_FOUND;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (reg_used[i] && reg_id[i] == key) begin
					r.st = ST_OK;
					r.found = reg_addr[i];
					break;
				end
			end
			if (r.st == ST_OK)
				n_hit++;
			else
				n_miss++;
		end else begin
			r.st = ST_FULL;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (!reg_used[i]) begin
					reg_id[i] = key;
					reg_addr[i] = it.addr;
					reg_used[i] = 1'b1;
					if (reg_count < TABLE_DEPTH)
						reg_count++;
					r.st = ST_OK;
					break;
				end
			end
			if (r.st == ST_OK)
				n_placed++;
			else
				n_refused++;
		end
		r.next_free = lowest_free_address();
		r.count = OUT_CNT_W'(reg_count);
		return r;
	endfunction

	task automatic report_error(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic push_lookup(logic [UID_W-1:0] id);
		node_req_t it;
		it.mode = MODE_LOOKUP;
		it.uid = id;
		it.addr = ADDR_W'($urandom_range(0, 255));
		pending_reqs.push_back(it);
	endtask

	task automatic push_add(logic [UID_W-1:0] id, logic [ADDR_W-1:0] addr);
		node_req_t it;
		it.mode = MODE_ADD;
		it.uid = id;
		it.addr = addr;
		pending_reqs.push_back(it);
		if (gen_adds < TABLE_DEPTH) begin
			gen_ids.push_back(id);
			gen_adds++;
		end
	endtask

	function automatic logic [UID_W-1:0] random_id();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [UID_W-1:0] enrolled_id();
		return gen_ids[$urandom_range(0, gen_ids.size() - 1)];
	endfunction

	task automatic build_random();
		int r;
		logic [ADDR_W-1:0] a;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if ((gen_adds < TABLE_DEPTH) ? (r < 2) : (r < 20)) begin
				if ($urandom_range(0, 1) == 0) begin
					a = ADDR_W'(seq_addr);
					seq_addr = (seq_addr >= TABLE_DEPTH) ? 1 : seq_addr + 1;
				end else begin
					a = ADDR_W'($urandom_range(0, 255));
				end
				if ($urandom_range(0, 9) < 3)
					push_add(enrolled_id(), a);
				else
					push_add(random_id(), a);
			end else begin
				r = $urandom_range(0, 9);
				if (r < 6)
					push_lookup(enrolled_id());
				else if (r < 8)
					push_lookup(enrolled_id() ^ (64'd1 << $urandom_range(0, 63)));
				else
					push_lookup(random_id());
			end
		end
	endtask

	// request driver
	node_req_t drv_item;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				expected_rsps.push_back(apply_registry(drv_item));
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 14)) begin
					drv_item = pending_reqs.pop_front();
					req_valid <= 1'b1;
					mode <= drv_item.mode;
					unique_id <= drv_item.uid;
					node_address <= drv_item.addr;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin
		node_rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					report_error("result with no item outstanding");
				end else begin
					want = expected_rsps.pop_front();
					if (status !== want.st)
						report_error($sformatf("status got %0d want %0d", status, want.st));
					if (found_address !== want.found)
						report_error($sformatf("found_address got %0d want %0d",
							found_address, want.found));
					if (next_free_address !== want.next_free)
						report_error($sformatf("next_free_address got %0d want %0d",
							next_free_address, want.next_free));
					if (entry_count !== want.count)
						report_error($sformatf("entry_count got %0d want %0d",
							entry_count, want.count));
				end
			end
			rsp_stall <= !quiet && ($urandom_range(0, 99) < 14);
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cyc);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		// empty table, extreme IDs
		push_lookup('0);
		push_lookup('1);
		// addresses 0 and 255 are ordinary
		push_add('1, 8'd0);
		push_lookup('1);
		push_add('0, 8'd255);
		push_lookup('0);
		// duplicate ID: first match wins
		push_add(64'h0123_4567_89ab_cdef, 8'd1);
		push_add(64'h0123_4567_89ab_cdef, 8'd2);
		push_lookup(64'h0123_4567_89ab_cdef);
		push_lookup(64'h0123_4567_89ab_cdee);
		push_lookup(64'h8123_4567_89ab_cdef);
		// duplicate address
		push_add(64'hfedc_ba98_7654_3210, 8'd1);
		push_lookup(64'hfedc_ba98_7654_3210);
		push_lookup(64'h5555_aaaa_5555_aaaa);
		build_random();

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		if (expected_rsps.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_rsps.size()));
		$display("Ran %0d lookups (%0d hits, %0d misses) and %0d adds (%0d placed, %0d refused).",
			n_hit + n_miss, n_hit, n_miss, n_placed + n_refused, n_placed, n_refused);
		$display("Table ended with %0d entries, %0d mismatches seen.", reg_count, err_cnt);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
